/* src/arpr_pkg.sv */
package arpr_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int REQUEST_ENTRIES_DEF = 16;
  localparam int PENDING_SLOTS_DEF   = 16;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] FK_IPV4 = 2'd0;
  localparam logic [1:0] FK_ARP  = 2'd1;

  localparam logic [2:0] RK_IPV4      = 3'd0;
  localparam logic [2:0] RK_ARP_REQ   = 3'd1;
  localparam logic [2:0] RK_ARP_REPLY = 3'd2;
  localparam logic [2:0] RK_DELIVER   = 3'd3;
  localparam logic [2:0] RK_DROP      = 3'd4;

  localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [1:0] CFG_LIFETIME = 2'd2;
  localparam logic [1:0] CFG_HOLDOFF  = 2'd3;

  localparam logic [15:0] LIFETIME_RST = 16'd30000;
  localparam logic [15:0] HOLDOFF_RST  = 16'd5000;
  localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;

  // source of an emitted result
  localparam logic [2:0] SRC_CACHE   = 3'd0;
  localparam logic [2:0] SRC_REQ     = 3'd1;
  localparam logic [2:0] SRC_DROP    = 3'd2;
  localparam logic [2:0] SRC_DELIVER = 3'd3;
  localparam logic [2:0] SRC_REPLY   = 3'd4;
  localparam logic [2:0] SRC_PEND    = 3'd5;

  typedef struct packed {
    logic       load;
    logic       clk_add;
    logic       c_step;
    logic       c_inval;
    logic       c_pick;
    logic       c_learn;
    logic       r_step;
    logic       r_pick;
    logic       r_write;
    logic       p_step;
    logic       p_keep;
    logic       p_done;
    logic       park;
    logic       mark;
    logic       mark_clr;
    logic       flush;
    logic       emit;
    logic [2:0] emit_src;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] fkind;
    logic       ok;
    logic       filt;
    logic       reply_ok;
    logic       c_end;
    logic       c_match;
    logic       c_fresh;
    logic       c_stale;
    logic       r_end;
    logic       hold;
    logic       p_scan_done;
    logic       p_match;
    logic       p_full;
    logic       mark_now;
    logic       mark;
  } stat_t;

endpackage

/* src/arpr_ctrl.sv */
module arpr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  arpr_pkg::stat_t st,
  output arpr_pkg::cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_SC   = 4'd2;
  localparam logic [3:0] ST_SR   = 4'd3;
  localparam logic [3:0] ST_SQ   = 4'd4;
  localparam logic [3:0] ST_SP   = 4'd5;
  localparam logic [3:0] ST_RC   = 4'd6;
  localparam logic [3:0] ST_RL   = 4'd7;
  localparam logic [3:0] ST_RP   = 4'd8;
  localparam logic [3:0] ST_TC   = 4'd9;
  localparam logic [3:0] ST_TP   = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_DONE;
        case (st.op)
          arpr_pkg::OP_SEND: state_nxt = ST_SC;
          arpr_pkg::OP_RECV: begin
            if (st.filt && st.ok) begin
              if (st.fkind == arpr_pkg::FK_IPV4) begin
                cmd.emit = 1'b1;
                cmd.emit_src = arpr_pkg::SRC_DELIVER;
              end else if (st.fkind == arpr_pkg::FK_ARP) begin
                state_nxt = ST_RC;
              end
            end
          end
          arpr_pkg::OP_TICK: begin
            cmd.clk_add = 1'b1;
            state_nxt = ST_TC;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SC: begin
        if (st.c_match && st.c_fresh) begin
          cmd.emit = 1'b1;
          cmd.emit_src = arpr_pkg::SRC_CACHE;
          state_nxt = ST_DONE;
        end else begin
          // stale hit is evicted on the way
          cmd.c_inval = st.c_match;
          cmd.c_step = 1'b1;
          if (st.c_end) state_nxt = ST_SR;
        end
      end
      ST_SR: begin
        cmd.r_pick = 1'b1;
        cmd.r_step = 1'b1;
        if (st.r_end) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (!st.hold) begin
          cmd.emit = 1'b1;
          cmd.emit_src = arpr_pkg::SRC_REQ;
          cmd.r_write = 1'b1;
        end
        state_nxt = ST_SP;
      end
      ST_SP: begin
        if (st.p_full) begin
          cmd.emit = 1'b1;
          cmd.emit_src = arpr_pkg::SRC_DROP;
        end else begin
          cmd.park = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_RC: begin
        cmd.c_pick = 1'b1;
        cmd.c_step = 1'b1;
        if (st.c_end) state_nxt = ST_RL;
      end
      ST_RL: begin
        cmd.c_learn = 1'b1;
        if (st.reply_ok) begin
          cmd.emit = 1'b1;
          cmd.emit_src = arpr_pkg::SRC_REPLY;
        end
        state_nxt = ST_RP;
      end
      ST_RP: begin
        if (st.p_scan_done) begin
          cmd.p_done = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          if (st.p_match) begin
            cmd.emit = 1'b1;
            cmd.emit_src = arpr_pkg::SRC_PEND;
          end else begin
            cmd.p_keep = 1'b1;
          end
          cmd.p_step = 1'b1;
        end
      end
      ST_TC: begin
        cmd.c_inval = st.c_stale;
        cmd.c_step = 1'b1;
        if (st.c_end) state_nxt = ST_TP;
      end
      ST_TP: begin
        // each pending entry is checked against every request entry
        if (st.p_scan_done) begin
          cmd.p_done = 1'b1;
          state_nxt = ST_DONE;
        end else if (st.r_end) begin
          cmd.p_keep = !(st.mark || st.mark_now);
          cmd.p_step = 1'b1;
          cmd.mark_clr = 1'b1;
          cmd.r_step = 1'b1;
        end else begin
          cmd.mark = 1'b1;
          cmd.r_step = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_DISP))
    else $error("accepted request not dispatched");

endmodule

/* src/arpr_dp.sv */
module arpr_dp #(
  parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
  parameter int REQUEST_ENTRIES = arpr_pkg::REQUEST_ENTRIES_DEF,
  parameter int PENDING_SLOTS   = arpr_pkg::PENDING_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [47:0]     cfg_wdata,
  input  logic [1:0]      in_opcode,
  input  logic [31:0]     in_next_hop_ip,
  input  logic [15:0]     in_datagram_handle,
  input  logic [47:0]     in_frame_dst_mac,
  input  logic [1:0]      in_frame_kind,
  input  logic            in_parse_ok,
  input  logic            in_arp_is_request,
  input  logic [31:0]     in_arp_sender_ip,
  input  logic [47:0]     in_arp_sender_mac,
  input  logic [31:0]     in_arp_target_ip,
  input  logic [15:0]     in_elapsed_ms,
  input  arpr_pkg::cmd_t  cmd,
  output arpr_pkg::stat_t st,
  output logic            out_valid,
  output logic [2:0]      out_result_kind,
  output logic [47:0]     out_dest_mac,
  output logic [31:0]     out_query_ip,
  output logic [15:0]     out_handle_out,
  output logic            out_last
);

  localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int RIW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int PIW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int PCW = $clog2(PENDING_SLOTS + 1);

  // configuration
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [15:0] life_r, holdoff_r;
  logic [31:0] clock_r;

  // latched request
  logic [1:0]  op_r, fk_r;
  logic [31:0] hop_r, sip_r, tip_r;
  logic [15:0] hdl_r, el_r;
  logic [47:0] dst_r, smac_r;
  logic        ok_r, isreq_r;

  // tables
  logic [CACHE_ENTRIES-1:0]   cv_r;
  logic [31:0]                cip_r    [CACHE_ENTRIES];
  logic [47:0]                cmac_r   [CACHE_ENTRIES];
  logic [31:0]                cstamp_r [CACHE_ENTRIES];
  logic [REQUEST_ENTRIES-1:0] rv_r;
  logic [31:0]                rip_r    [REQUEST_ENTRIES];
  logic [31:0]                rstamp_r [REQUEST_ENTRIES];
  logic [31:0]                pip_r    [PENDING_SLOTS];
  logic [15:0]                phdl_r   [PENDING_SLOTS];
  logic [PCW-1:0]             pcnt_r;

  // scan pointers and accumulators
  logic [CIW-1:0] ci_r, c_fslot_r, c_free_r, c_old_r, c_slot;
  logic [RIW-1:0] ri_r, r_fslot_r, r_free_r, r_old_r, r_slot;
  logic [PCW-1:0] pi_r, pj_r;
  logic [PIW-1:0] pidx, pjdx, pcdx;
  logic           c_found_r, c_freef_r, r_found_r, r_freef_r, hold_r, mark_r;
  logic [31:0]    c_best_r, r_best_r;

  // result waiting to learn whether it is the last one
  logic        hv_r;
  logic [2:0]  hk_r;
  logic [47:0] hmac_r;
  logic [31:0] hip_r;
  logic [15:0] hhdl_r;

  logic        out_valid_r, out_last_r;
  logic [2:0]  out_kind_r;
  logic [47:0] out_mac_r;
  logic [31:0] out_ip_r;
  logic [15:0] out_hdl_r;

  logic [2:0]  res_kind_nxt;
  logic [47:0] res_mac_nxt;
  logic [31:0] res_ip_nxt;
  logic [15:0] res_hdl_nxt;

  logic [31:0] ckey, cage, rage;
  logic        c_end, r_end, rmatch_hop, c_any_match;

  assign pidx = pi_r[PIW-1:0];
  assign pjdx = pj_r[PIW-1:0];
  assign pcdx = pcnt_r[PIW-1:0];

  assign ckey = (op_r == arpr_pkg::OP_SEND) ? hop_r : sip_r;
  assign cage = clock_r - cstamp_r[ci_r];
  assign rage = clock_r - rstamp_r[ri_r];
  assign c_end = (ci_r == CIW'(CACHE_ENTRIES - 1));
  assign r_end = (ri_r == RIW'(REQUEST_ENTRIES - 1));
  assign c_any_match = cv_r[ci_r] && (cip_r[ci_r] == ckey);
  assign rmatch_hop = rv_r[ri_r] && (rip_r[ri_r] == hop_r);

  assign c_slot = c_found_r ? c_fslot_r : (c_freef_r ? c_free_r : c_old_r);
  assign r_slot = r_found_r ? r_fslot_r : (r_freef_r ? r_free_r : r_old_r);

  always_comb begin
    st = '0;
    st.op = op_r;
    st.fkind = fk_r;
    st.ok = ok_r;
    st.filt = (dst_r == own_mac_r) || (dst_r == arpr_pkg::BCAST_MAC);
    st.reply_ok = isreq_r && (tip_r == own_ip_r);
    st.c_end = c_end;
    st.c_match = c_any_match;
    st.c_fresh = (cage <= {16'd0, life_r});
    st.c_stale = cv_r[ci_r] && (cage > {16'd0, life_r});
    st.r_end = r_end;
    st.hold = hold_r;
    st.p_scan_done = (pi_r == pcnt_r);
    st.p_match = (pip_r[pidx] == sip_r);
    st.p_full = (pcnt_r == PCW'(PENDING_SLOTS));
    st.mark_now = rv_r[ri_r] && (rip_r[ri_r] == pip_r[pidx])
                  && (rage > {16'd0, holdoff_r});
    st.mark = mark_r;
  end

  always_comb begin
    res_kind_nxt = arpr_pkg::RK_IPV4;
    res_mac_nxt = '0;
    res_ip_nxt = '0;
    res_hdl_nxt = '0;
    case (cmd.emit_src)
      arpr_pkg::SRC_CACHE: begin
        res_mac_nxt = cmac_r[ci_r];
        res_hdl_nxt = hdl_r;
      end
      arpr_pkg::SRC_REQ: begin
        res_kind_nxt = arpr_pkg::RK_ARP_REQ;
        res_mac_nxt = arpr_pkg::BCAST_MAC;
        res_ip_nxt = hop_r;
      end
      arpr_pkg::SRC_DROP: begin
        res_kind_nxt = arpr_pkg::RK_DROP;
        res_hdl_nxt = hdl_r;
      end
      arpr_pkg::SRC_DELIVER: begin
        res_kind_nxt = arpr_pkg::RK_DELIVER;
        res_hdl_nxt = hdl_r;
      end
      arpr_pkg::SRC_REPLY: begin
        res_kind_nxt = arpr_pkg::RK_ARP_REPLY;
        res_mac_nxt = smac_r;
        res_ip_nxt = sip_r;
      end
      arpr_pkg::SRC_PEND: begin
        res_mac_nxt = smac_r;
        res_hdl_nxt = phdl_r[pidx];
      end
      default: res_kind_nxt = arpr_pkg::RK_IPV4;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r <= '0;
      life_r <= arpr_pkg::LIFETIME_RST;
      holdoff_r <= arpr_pkg::HOLDOFF_RST;
      clock_r <= '0;
      cv_r <= '0;
      rv_r <= '0;
      pcnt_r <= '0;
      ci_r <= '0;
      ri_r <= '0;
      pi_r <= '0;
      pj_r <= '0;
      c_found_r <= 1'b0;
      c_freef_r <= 1'b0;
      r_found_r <= 1'b0;
      r_freef_r <= 1'b0;
      hold_r <= 1'b0;
      mark_r <= 1'b0;
      hv_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          arpr_pkg::CFG_OWN_MAC:  own_mac_r <= cfg_wdata;
          arpr_pkg::CFG_OWN_IP:   own_ip_r <= cfg_wdata[31:0];
          arpr_pkg::CFG_LIFETIME: life_r <= cfg_wdata[15:0];
          arpr_pkg::CFG_HOLDOFF:  holdoff_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        ci_r <= '0;
        ri_r <= '0;
        pi_r <= '0;
        pj_r <= '0;
        c_found_r <= 1'b0;
        c_freef_r <= 1'b0;
        r_found_r <= 1'b0;
        r_freef_r <= 1'b0;
        hold_r <= 1'b0;
        mark_r <= 1'b0;
      end
      if (cmd.clk_add) clock_r <= clock_r + {16'd0, el_r};
      if (cmd.c_step) ci_r <= c_end ? '0 : ci_r + 1'b1;
      if (cmd.c_inval) cv_r[ci_r] <= 1'b0;
      if (cmd.c_pick) begin
        if (cv_r[ci_r] && (cip_r[ci_r] == sip_r) && !c_found_r) c_found_r <= 1'b1;
        if (!cv_r[ci_r] && !c_freef_r) c_freef_r <= 1'b1;
      end
      if (cmd.c_learn) cv_r[c_slot] <= 1'b1;
      if (cmd.r_step) ri_r <= r_end ? '0 : ri_r + 1'b1;
      if (cmd.r_pick) begin
        if (rmatch_hop && !r_found_r) r_found_r <= 1'b1;
        if (!rv_r[ri_r] && !r_freef_r) r_freef_r <= 1'b1;
        if (rmatch_hop && (rage < {16'd0, holdoff_r})) hold_r <= 1'b1;
      end
      if (cmd.r_write) rv_r[r_slot] <= 1'b1;
      if (cmd.park) pcnt_r <= pcnt_r + 1'b1;
      if (cmd.p_keep) pj_r <= pj_r + 1'b1;
      if (cmd.p_step) pi_r <= pi_r + 1'b1;
      if (cmd.p_done) pcnt_r <= pj_r;
      if (cmd.mark) mark_r <= mark_r | st.mark_now;
      if (cmd.mark_clr) mark_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
      if (cmd.emit) begin
        hv_r <= 1'b1;
        if (hv_r) begin
          out_valid_r <= 1'b1;
          out_last_r <= 1'b0;
        end
      end else if (cmd.flush && hv_r) begin
        hv_r <= 1'b0;
        out_valid_r <= 1'b1;
        out_last_r <= 1'b1;
      end
    end
  end

  // payload and tables
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      hop_r <= in_next_hop_ip;
      hdl_r <= in_datagram_handle;
      dst_r <= in_frame_dst_mac;
      fk_r <= in_frame_kind;
      ok_r <= in_parse_ok;
      isreq_r <= in_arp_is_request;
      sip_r <= in_arp_sender_ip;
      smac_r <= in_arp_sender_mac;
      tip_r <= in_arp_target_ip;
      el_r <= in_elapsed_ms;
      c_best_r <= '0;
      c_old_r <= '0;
      r_best_r <= '0;
      r_old_r <= '0;
    end
    if (cmd.c_pick) begin
      if (cv_r[ci_r] && (cip_r[ci_r] == sip_r) && !c_found_r) c_fslot_r <= ci_r;
      if (!cv_r[ci_r] && !c_freef_r) c_free_r <= ci_r;
      if (cv_r[ci_r] && (cage > c_best_r)) begin
        c_best_r <= cage;
        c_old_r <= ci_r;
      end
    end
    if (cmd.c_learn) begin
      cip_r[c_slot] <= sip_r;
      cmac_r[c_slot] <= smac_r;
      cstamp_r[c_slot] <= clock_r;
    end
    if (cmd.r_pick) begin
      if (rmatch_hop && !r_found_r) r_fslot_r <= ri_r;
      if (!rv_r[ri_r] && !r_freef_r) r_free_r <= ri_r;
      if (rv_r[ri_r] && (rage > r_best_r)) begin
        r_best_r <= rage;
        r_old_r <= ri_r;
      end
    end
    if (cmd.r_write) begin
      rip_r[r_slot] <= hop_r;
      rstamp_r[r_slot] <= clock_r;
    end
    if (cmd.park) begin
      pip_r[pcdx] <= hop_r;
      phdl_r[pcdx] <= hdl_r;
    end
    // compaction: write slot never runs ahead of read slot
    if (cmd.p_keep) begin
      pip_r[pjdx] <= pip_r[pidx];
      phdl_r[pjdx] <= phdl_r[pidx];
    end
    if (cmd.emit) begin
      hk_r <= res_kind_nxt;
      hmac_r <= res_mac_nxt;
      hip_r <= res_ip_nxt;
      hhdl_r <= res_hdl_nxt;
    end
    if ((cmd.emit || cmd.flush) && hv_r) begin
      out_kind_r <= hk_r;
      out_mac_r <= hmac_r;
      out_ip_r <= hip_r;
      out_hdl_r <= hhdl_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_last = out_last_r;
  assign out_result_kind = out_kind_r;
  assign out_dest_mac = out_mac_r;
  assign out_query_ip = out_ip_r;
  assign out_handle_out = out_hdl_r;

  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCW'(PENDING_SLOTS))
    else $error("pending count beyond capacity");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last flag without result");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && !cmd.emit) |=> !hv_r)
    else $error("held result survived flush");

  a_emit_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && hv_r) |=> (out_valid_r && !out_last_r))
    else $error("held result lost on new emit");

endmodule

/* src/arp_resolver_with_pending_queue.sv */
// ARP resolver for one IPv4/Ethernet interface. Pulse start while busy is low to hand in a
// send, receive or tick request; results come out one per cycle on out_valid and cannot be
// held off, with out_last marking the final result of a request. A request is worked through
// by table scans, one entry per cycle: a send scans the cache (stopping early on a fresh
// hit) and then the request table, an ARP receive the cache and then the pending entries,
// a tick the cache and then each pending entry against every request entry. No reset
// sweep is needed. The user must write configuration only while busy is low; the block
// does not enforce this.
module arp_resolver_with_pending_queue #(
  parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
  parameter int REQUEST_ENTRIES = arpr_pkg::REQUEST_ENTRIES_DEF,
  parameter int PENDING_SLOTS   = arpr_pkg::PENDING_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_next_hop_ip,
  input  logic [15:0] in_datagram_handle,
  input  logic [47:0] in_frame_dst_mac,
  input  logic [1:0]  in_frame_kind,
  input  logic        in_parse_ok,
  input  logic        in_arp_is_request,
  input  logic [31:0] in_arp_sender_ip,
  input  logic [47:0] in_arp_sender_mac,
  input  logic [31:0] in_arp_target_ip,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  output logic [2:0]  out_result_kind,
  output logic [47:0] out_dest_mac,
  output logic [31:0] out_query_ip,
  output logic [15:0] out_handle_out,
  output logic        out_last
);

  arpr_pkg::cmd_t  cmd;
  arpr_pkg::stat_t st;

  arpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  arpr_dp #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .REQUEST_ENTRIES (REQUEST_ENTRIES),
    .PENDING_SLOTS   (PENDING_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_opcode          (in_opcode),
    .in_next_hop_ip     (in_next_hop_ip),
    .in_datagram_handle (in_datagram_handle),
    .in_frame_dst_mac   (in_frame_dst_mac),
    .in_frame_kind      (in_frame_kind),
    .in_parse_ok        (in_parse_ok),
    .in_arp_is_request  (in_arp_is_request),
    .in_arp_sender_ip   (in_arp_sender_ip),
    .in_arp_sender_mac  (in_arp_sender_mac),
    .in_arp_target_ip   (in_arp_target_ip),
    .in_elapsed_ms      (in_elapsed_ms),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_dest_mac       (out_dest_mac),
    .out_query_ip       (out_query_ip),
    .out_handle_out     (out_handle_out),
    .out_last           (out_last)
  );

endmodule

/* dv/tb_arp_resolver_with_pending_queue.sv */
module tb_arp_resolver_with_pending_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NC = 16;
  localparam int NR = 16;
  localparam int NP = 16;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] hop;
    logic [15:0] handle;
    logic [47:0] dst;
    logic [1:0]  fkind;
    logic        ok;
    logic        is_req;
    logic [31:0] s_ip;
    logic [47:0] s_mac;
    logic [31:0] t_ip;
    logic [15:0] elapsed;
  } arp_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] handle;
    logic        last;
  } arp_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = arpr_pkg::CFG_OWN_MAC;
  logic [47:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  arp_item_t drv = '0;
  logic out_valid, out_last;
  logic [2:0] out_result_kind;
  logic [47:0] out_dest_mac;
  logic [31:0] out_query_ip;
  logic [15:0] out_handle_out;

  always #1 clk = ~clk;

  arp_resolver_with_pending_queue uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_opcode(drv.opcode), .in_next_hop_ip(drv.hop), .in_datagram_handle(drv.handle),
    .in_frame_dst_mac(drv.dst), .in_frame_kind(drv.fkind), .in_parse_ok(drv.ok),
    .in_arp_is_request(drv.is_req), .in_arp_sender_ip(drv.s_ip),
    .in_arp_sender_mac(drv.s_mac), .in_arp_target_ip(drv.t_ip),
    .in_elapsed_ms(drv.elapsed),
    .out_valid(out_valid), .out_result_kind(out_result_kind), .out_dest_mac(out_dest_mac),
    .out_query_ip(out_query_ip), .out_handle_out(out_handle_out), .out_last(out_last)
  );

  // shadow of the resolver state
  logic [47:0] m_mac;
  logic [31:0] m_ip;
  logic [31:0] m_life, m_hold, now_ms;
  logic        c_v[NC];
  logic [31:0] c_ip[NC], c_st[NC];
  logic [47:0] c_mac[NC];
  logic        r_v[NR];
  logic [31:0] r_ip[NR], r_st[NR];
  logic        p_v[NP];
  logic [31:0] p_ip[NP];
  logic [15:0] p_h[NP];

  arp_res_t expected_q[$];
  int errors = 0;

  task automatic push_res(input logic [2:0] k, input logic [47:0] mac,
                          input logic [31:0] ip, input logic [15:0] h);
    arp_res_t r;
    r.kind = k; r.mac = mac; r.ip = ip; r.handle = h; r.last = 1'b0;
    expected_q.push_back(r);
  endtask

  function automatic int oldest_or_free(input bit cache, input logic [31:0] key);
    int fr, old;
    logic [31:0] best, age;
    fr = -1; old = 0; best = 0;
    for (int i = 0; i < 16; i++)
      if ((cache ? c_v[i] : r_v[i]) && (cache ? c_ip[i] : r_ip[i]) == key) return i;
    for (int i = 0; i < 16; i++) begin
      if (!(cache ? c_v[i] : r_v[i])) begin
        if (fr < 0) fr = i;
      end else begin
        age = now_ms - (cache ? c_st[i] : r_st[i]);
        if (age > best) begin
          best = age;
          old = i;
        end
      end
    end
    return fr >= 0 ? fr : old;
  endfunction

  task automatic pend_squeeze(input bit keep[NP]);
    int j;
    j = 0;
    for (int i = 0; i < NP; i++)
      if (p_v[i] && keep[i]) begin
        p_ip[j] = p_ip[i];
        p_h[j] = p_h[i];
        j++;
      end
    for (int i = 0; i < NP; i++) p_v[i] = (i < j);
  endtask

  task automatic resolve(input arp_item_t it);
    int n0, c, s;
    bit hold, keep[NP];
    n0 = expected_q.size();
    if (it.opcode == arpr_pkg::OP_SEND) begin
      hold = 0;
      for (int i = 0; i < NC; i++)
        if (c_v[i] && c_ip[i] == it.hop) begin
          if (now_ms - c_st[i] <= m_life) begin
            push_res(arpr_pkg::RK_IPV4, c_mac[i], '0, it.handle);
            expected_q[$].last = 1'b1;
            return;
          end
          c_v[i] = 0;
        end
      for (int i = 0; i < NR; i++)
        if (r_v[i] && r_ip[i] == it.hop && now_ms - r_st[i] < m_hold) hold = 1;
      if (!hold) begin
        s = oldest_or_free(0, it.hop);
        push_res(arpr_pkg::RK_ARP_REQ, arpr_pkg::BCAST_MAC, it.hop, '0);
        r_v[s] = 1; r_ip[s] = it.hop; r_st[s] = now_ms;
      end
      c = NP;
      for (int i = NP - 1; i >= 0; i--) if (!p_v[i]) c = i;
      if (c < NP) begin
        p_v[c] = 1; p_ip[c] = it.hop; p_h[c] = it.handle;
      end else push_res(arpr_pkg::RK_DROP, '0, '0, it.handle);
    end else if (it.opcode == arpr_pkg::OP_RECV) begin
      if (it.dst != m_mac && it.dst != arpr_pkg::BCAST_MAC) return;
      if (it.fkind == arpr_pkg::FK_IPV4) begin
        if (it.ok) push_res(arpr_pkg::RK_DELIVER, '0, '0, it.handle);
      end else if (it.fkind == arpr_pkg::FK_ARP && it.ok) begin
        s = oldest_or_free(1, it.s_ip);
        c_v[s] = 1; c_ip[s] = it.s_ip; c_mac[s] = it.s_mac; c_st[s] = now_ms;
        if (it.is_req && it.t_ip == m_ip)
          push_res(arpr_pkg::RK_ARP_REPLY, it.s_mac, it.s_ip, '0);
        for (int i = 0; i < NP; i++) begin
          keep[i] = 1;
          if (p_v[i] && p_ip[i] == it.s_ip) begin
            push_res(arpr_pkg::RK_IPV4, it.s_mac, '0, p_h[i]);
            keep[i] = 0;
          end
        end
        pend_squeeze(keep);
      end
    end else if (it.opcode == arpr_pkg::OP_TICK) begin
      now_ms = now_ms + it.elapsed;
      for (int i = 0; i < NC; i++)
        if (c_v[i] && now_ms - c_st[i] > m_life) c_v[i] = 0;
      for (int i = 0; i < NP; i++) begin
        keep[i] = 1;
        if (p_v[i])
          for (int k = 0; k < NR; k++)
            if (r_v[k] && r_ip[k] == p_ip[i] && now_ms - r_st[k] > m_hold) keep[i] = 0;
      end
      pend_squeeze(keep);
    end
    if (expected_q.size() > n0) expected_q[$].last = 1'b1;
  endtask

  // results cannot be held off, so check every strobe
  always @(posedge clk) begin
    arp_res_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d handle=%0h", out_result_kind, out_handle_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_result_kind !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, out_result_kind); errors++;
        end
        if (out_dest_mac !== e.mac) begin
          $error("dest_mac exp %0h got %0h", e.mac, out_dest_mac); errors++;
        end
        if (out_query_ip !== e.ip) begin
          $error("query_ip exp %0h got %0h", e.ip, out_query_ip); errors++;
        end
        if (out_handle_out !== e.handle) begin
          $error("handle_out exp %0h got %0h", e.handle, out_handle_out); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  bit idle_on = 1;

  task automatic send_request(input arp_item_t it);
    if (idle_on)
      while ($urandom_range(99) < 36) @(posedge clk);
    start <= 1'b1;
    drv <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    resolve(it);
    start <= 1'b0;
    // block is busy for this cycle anyway
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      arpr_pkg::CFG_OWN_MAC:  m_mac = val;
      arpr_pkg::CFG_OWN_IP:   m_ip = val[31:0];
      arpr_pkg::CFG_LIFETIME: m_life = {16'd0, val[15:0]};
      default:                m_hold = {16'd0, val[15:0]};
    endcase
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  localparam logic [31:0] IP_A = 32'h0A00_0001;
  localparam logic [31:0] IP_ME = 32'hC0A8_0001;
  localparam logic [47:0] MAC_ME = 48'h0200_0000_0001;

  function automatic arp_item_t mk(input logic [1:0] op, input logic [31:0] hop,
      input logic [15:0] h, input logic [47:0] dst, input logic [1:0] fk, input logic ok,
      input logic rq, input logic [31:0] sip, input logic [47:0] smac,
      input logic [31:0] tip, input logic [15:0] el);
    arp_item_t t;
    t.opcode = op; t.hop = hop; t.handle = h; t.dst = dst; t.fkind = fk; t.ok = ok;
    t.is_req = rq; t.s_ip = sip; t.s_mac = smac; t.t_ip = tip; t.elapsed = el;
    return t;
  endfunction

  function automatic logic [31:0] pick_ip();
    logic [31:0] pool[6] = '{IP_A, 32'h0A00_0002, 32'h0A00_0003, 32'h0A00_0004,
                             IP_ME, 32'hFFFF_FFFF};
    if ($urandom_range(9) == 0) return $urandom;
    return pool[$urandom_range(5)];
  endfunction

  function automatic arp_item_t rand_item();
    arp_item_t t;
    int r;
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(arp_item_t)-1:0];
    r = $urandom_range(99);
    t.hop = pick_ip(); t.s_ip = pick_ip(); t.t_ip = pick_ip();
    t.ok = $urandom_range(9) != 0;
    t.elapsed = $urandom_range(3) == 0 ? t.elapsed : 16'($urandom_range(3000));
    if (r < 40) t.opcode = arpr_pkg::OP_SEND;
    else if (r < 85) begin
      t.opcode = arpr_pkg::OP_RECV;
      t.dst = $urandom_range(9) == 0 ? t.dst :
              ($urandom_range(1) ? m_mac : arpr_pkg::BCAST_MAC);
      t.fkind = $urandom_range(9) == 0 ? 2'($urandom_range(3)) :
                ($urandom_range(3) == 0 ? arpr_pkg::FK_IPV4 : arpr_pkg::FK_ARP);
    end else if (r < 97) t.opcode = arpr_pkg::OP_TICK;
    else t.opcode = 2'd3;
    return t;
  endfunction

  arp_item_t dir_tbl[$];
  bit dir_has[$];
  arp_res_t dir_exp[$];

  initial begin
    arp_item_t it;
    m_mac = '0; m_ip = '0; m_life = 30000; m_hold = 5000; now_ms = '0;
    for (int i = 0; i < 16; i++) begin
      c_v[i] = 0; r_v[i] = 0; p_v[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: own-mac config, then ip delivery with broadcast and further send, receive and tick rows
    dir_tbl = '{
      mk(arpr_pkg::OP_RECV, 0, 16'hFFFF, arpr_pkg::BCAST_MAC, arpr_pkg::FK_IPV4,
         1, 0, 0, 0, 0, 0),
      mk(arpr_pkg::OP_RECV, 0, 16'h0000, 48'h1, arpr_pkg::FK_IPV4, 1, 0, 0, 0, 0, 0),
      mk(arpr_pkg::OP_RECV, 0, 16'h1234, arpr_pkg::BCAST_MAC, arpr_pkg::FK_IPV4,
         0, 0, 0, 0, 0, 0),
      mk(arpr_pkg::OP_RECV, 0, 16'h1234, arpr_pkg::BCAST_MAC, 2'd2, 1, 0, 0, 0, 0, 0),
      mk(2'd3, 32'hFFFF_FFFF, 16'hFFFF, '1, 2'd3, 1, 1, '1, '1, '1, 16'hFFFF),
      mk(arpr_pkg::OP_SEND, IP_A, 16'h0001, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(arpr_pkg::OP_SEND, IP_A, 16'h0002, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(arpr_pkg::OP_RECV, 0, 0, MAC_ME, arpr_pkg::FK_ARP, 1, 1, IP_A,
         48'hAAAA_BBBB_CCCC, IP_ME, 0),
      mk(arpr_pkg::OP_SEND, IP_A, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(arpr_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF),
      mk(arpr_pkg::OP_SEND, IP_A, 16'h0003, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(arpr_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000)
    };
    dir_has = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_exp = '{'{arpr_pkg::RK_DELIVER, 48'h0, 32'h0, 16'hFFFF, 1'b1}};
    write_reg(arpr_pkg::CFG_OWN_MAC, MAC_ME);
    write_reg(arpr_pkg::CFG_OWN_IP, {16'd0, IP_ME[31:16]});
    write_reg(arpr_pkg::CFG_OWN_IP, {16'd0, IP_ME});
    for (int i = 0; i < dir_tbl.size(); i++) begin
      send_request(dir_tbl[i]);
      if (dir_has[i] && expected_q[$] !== dir_exp[0]) begin
        $error("directed row %0d predictor disagrees with table", i); errors++;
      end
    end
    // fill the pending store to force drops, then flush it
    for (int i = 0; i < 18; i++)
      send_request(mk(arpr_pkg::OP_SEND, 32'h0A00_0009, 16'(i), 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(arpr_pkg::OP_RECV, 0, 0, arpr_pkg::BCAST_MAC, arpr_pkg::FK_ARP, 1, 0,
                    32'h0A00_0009, 48'h5, 0, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(arpr_pkg::CFG_LIFETIME, 48'h0);
          write_reg(arpr_pkg::CFG_HOLDOFF, 48'h0);
        end
        1: begin
          write_reg(arpr_pkg::CFG_LIFETIME, 48'hFFFF);
          write_reg(arpr_pkg::CFG_HOLDOFF, 48'hFFFF);
        end
        2: begin
          write_reg(arpr_pkg::CFG_LIFETIME, 48'd4000);
          write_reg(arpr_pkg::CFG_HOLDOFF, 48'd1500);
          write_reg(arpr_pkg::CFG_OWN_MAC, '1 ^ 48'h1);
        end
        default: begin
          write_reg(arpr_pkg::CFG_LIFETIME, 48'd30000);
          write_reg(arpr_pkg::CFG_HOLDOFF, 48'd5000);
          write_reg(arpr_pkg::CFG_OWN_MAC, MAC_ME);
          write_reg(arpr_pkg::CFG_OWN_IP, 48'hFFFF_FFFF);
        end
      endcase
      idle_on = (ph != 1);
      for (int i = 0; i < 65; i++) begin
        it = rand_item();
        send_request(it);
      end
      drain();
    end
    if (expected_q.size() != 0) begin
      $error("pending results exp 0 got %0d", expected_q.size()); errors++;
    end
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
